// ===== hdl/tgarle_pkg.sv =====
package tgarle_pkg;

  localparam logic [1:0] REG_IMAGE_TYPE      = 2'd0;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] REG_ALPHA_ENABLE    = 2'd2;
  localparam logic [1:0] REG_PIXEL_COUNT     = 2'd3;

  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_16   = 2'd1;
  localparam logic [1:0] FMT_24   = 2'd2;
  localparam logic [1:0] FMT_32   = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  image_type;
    logic [2:0]  bytes_per_pixel;
    logic        alpha_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0][7:0] px;
    logic [1:0]      fmt;
    logic            alpha_enable;
    logic [7:0]      run_length;
    logic            last_run;
  } entry_t;

endpackage

// ===== hdl/tgarle_front.sv =====
module tgarle_front import tgarle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        restart,
  input  logic [31:0] restart_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        push,
  input  logic        push_ready,
  output entry_t      push_entry
);

  logic        expect_pkt, expect_pkt_next;
  logic        repeat_pkt, repeat_pkt_next;
  logic [6:0]  raw_left, raw_left_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [23:0] held, held_next;
  logic [31:0] pixels_left, pixels_left_next;

  logic       rle;
  logic [1:0] last_idx;
  logic [7:0] run_raw;
  logic [7:0] run;

  assign in_ready = push_ready;
  assign rle      = cfg.image_type[0];

  always_comb begin
    unique case (cfg.bytes_per_pixel)
      3'd0, 3'd1, 3'd2: last_idx = 2'd1;
      3'd3:             last_idx = 2'd2;
      default:          last_idx = 2'd3;
    endcase
  end

  always_comb begin
    expect_pkt_next  = expect_pkt;
    repeat_pkt_next  = repeat_pkt;
    raw_left_next    = raw_left;
    byte_pos_next    = byte_pos;
    held_next        = held;
    pixels_left_next = pixels_left;
    push             = 1'b0;
    run_raw          = 8'd1;
    run              = 8'd1;

    push_entry.px[0]        = held[7:0];
    push_entry.px[1]        = held[15:8];
    push_entry.px[2]        = held[23:16];
    push_entry.px[3]        = 8'd0;
    push_entry.px[last_idx] = in_byte;
    push_entry.alpha_enable = cfg.alpha_enable;
    if (cfg.image_type[1]) begin
      push_entry.fmt = FMT_GRAY;
    end else begin
      unique case (last_idx)
        2'd1:    push_entry.fmt = FMT_16;
        2'd2:    push_entry.fmt = FMT_24;
        default: push_entry.fmt = FMT_32;
      endcase
    end

    if (rle && repeat_pkt) begin
      run_raw = {1'b0, raw_left} + 8'd1;
    end
    if ({24'd0, run_raw} > pixels_left) begin
      run = pixels_left[7:0];
    end else begin
      run = run_raw;
    end
    push_entry.run_length = run;
    push_entry.last_run   = (pixels_left - {24'd0, run}) == 32'd0;

    if (in_valid && in_ready && pixels_left != 32'd0) begin
      if (rle && expect_pkt) begin
        repeat_pkt_next = in_byte[7];
        raw_left_next   = in_byte[6:0];
        expect_pkt_next = 1'b0;
      end else if (byte_pos < last_idx) begin
        unique case (byte_pos)
          2'd0:    held_next[7:0]   = held[7:0] | in_byte;
          2'd1:    held_next[15:8]  = held[15:8] | in_byte;
          2'd2:    held_next[23:16] = held[23:16] | in_byte;
          default: held_next        = held;
        endcase
        byte_pos_next = byte_pos + 2'd1;
      end else begin
        push          = 1'b1;
        held_next     = 24'd0;
        byte_pos_next = 2'd0;
        if (rle) begin
          if (repeat_pkt) begin
            raw_left_next   = 7'd0;
            expect_pkt_next = 1'b1;
          end else if (raw_left == 7'd0) begin
            expect_pkt_next = 1'b1;
          end else begin
            raw_left_next = raw_left - 7'd1;
          end
        end
        pixels_left_next = pixels_left - {24'd0, run};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_pkt  <= 1'b1;
      repeat_pkt  <= 1'b0;
      raw_left    <= 7'd0;
      byte_pos    <= 2'd0;
      held        <= 24'd0;
      pixels_left <= 32'd0;
    end else if (restart) begin
      expect_pkt  <= 1'b1;
      repeat_pkt  <= 1'b0;
      raw_left    <= 7'd0;
      byte_pos    <= 2'd0;
      held        <= 24'd0;
      pixels_left <= restart_count;
    end else begin
      expect_pkt  <= expect_pkt_next;
      repeat_pkt  <= repeat_pkt_next;
      raw_left    <= raw_left_next;
      byte_pos    <= byte_pos_next;
      held        <= held_next;
      pixels_left <= pixels_left_next;
    end
  end

endmodule

// ===== hdl/tgarle_queue.sv =====
module tgarle_queue import tgarle_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   push_ready,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   pop_valid,
  output entry_t pop_entry
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tgarle_back.sv =====
module tgarle_back import tgarle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  input  entry_t     pop_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] ch0,
  output logic [7:0] ch1,
  output logic [7:0] ch2,
  output logic [7:0] ch3,
  output logic [7:0] run_length,
  output logic       last_run
);

  logic [7:0]  c0, c1, c2, c3;
  logic [15:0] w;
  logic [15:0] w5551;

  assign pop   = pop_valid && (!out_valid || out_ready);
  assign w     = {pop_entry.px[1], pop_entry.px[0]};
  assign w5551 = {w[14:0], pop_entry.alpha_enable ? w[15] : 1'b1};

  always_comb begin
    c2 = 8'd0;
    c3 = 8'd0;
    unique case (pop_entry.fmt)
      FMT_GRAY: begin
        c0 = pop_entry.px[0];
        c1 = pop_entry.alpha_enable ? pop_entry.px[1] : 8'd255;
      end
      FMT_16: begin
        c0 = w5551[7:0];
        c1 = w5551[15:8];
      end
      FMT_24: begin
        c0 = pop_entry.px[2];
        c1 = pop_entry.px[1];
        c2 = pop_entry.px[0];
      end
      default: begin
        c0 = pop_entry.px[2];
        c1 = pop_entry.px[1];
        c2 = pop_entry.px[0];
        c3 = pop_entry.alpha_enable ? pop_entry.px[3] : 8'd255;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch0        <= c0;
      ch1        <= c1;
      ch2        <= c2;
      ch3        <= c3;
      run_length <= pop_entry.run_length;
      last_run   <= pop_entry.last_run;
    end
  end

endmodule

// ===== hdl/tga_rle_pixel_decoder_unit.sv =====
// TGA pixel-data decoder (raw and RLE, color and gray).
// Input channel in_valid/in_ready/in_byte: one byte of packet or pixel data
// per item, after the file header. Config channel cfg_valid/cfg_ready with
// cfg_index/cfg_data: 0 image type, 1 bytes per pixel, 2 alpha enable,
// 3 pixel count (a write restarts the parse). Write config only while idle.
// Output channel out_valid/out_ready: one converted pixel per item with its
// run length and a flag on the run that completes the image.
// Throughput: one byte per cycle while in_ready is high. The edge that
// takes a pixel's last byte writes it into the queue, and a later edge
// loads it from there into the output register. The front parser and the back
// converter are joined by a two-entry queue; when the receiver stalls, the
// queue fills and in_ready drops only once both entries and the output
// register are occupied.
// Bytes after the image is complete are taken and dropped.
// Reset: image type RLE color, 4 bytes per pixel, alpha on, pixel count 0,
// so all bytes are dropped until a pixel count is written.
module tga_rle_pixel_decoder_unit import tgarle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  ch0,
  output logic [7:0]  ch1,
  output logic [7:0]  ch2,
  output logic [7:0]  ch3,
  output logic [7:0]  run_length,
  output logic        last_run
);

  cfg_t   cfg;
  logic   cfg_write;
  logic   restart;
  logic   push;
  logic   push_ready;
  entry_t push_entry;
  logic   pop;
  logic   pop_valid;
  entry_t pop_entry;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write && (cfg_index == REG_PIXEL_COUNT);

  // pixel count goes straight to the front parser on restart
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_type      <= 2'd1;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.alpha_enable    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_TYPE:      cfg.image_type      <= cfg_data[1:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        REG_ALPHA_ENABLE:    cfg.alpha_enable    <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .restart       (restart),
    .restart_count (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .push          (push),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  tgarle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ch0        (ch0),
    .ch1        (ch1),
    .ch2        (ch2),
    .ch3        (ch3),
    .run_length (run_length),
    .last_run   (last_run)
  );

endmodule

// ===== bench/tga_rle_pixel_decoder_unit_tb.sv =====
module tga_rle_pixel_decoder_unit_tb;
  import tgarle_pkg::*;

  localparam logic [1:0] IMG_RAW_COLOR = 2'd0;
  localparam logic [1:0] IMG_RLE_COLOR = 2'd1;
  localparam logic [1:0] IMG_RAW_GRAY  = 2'd2;
  localparam logic [1:0] IMG_RLE_GRAY  = 2'd3;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int BYTE_GOAL    = 400;
  localparam int CALM_FROM    = 330;
  localparam int SCRIPT_LEN   = 39;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [7:0] ch3;
    logic [7:0] run_len;
    logic       last;
  } pixel_t;

  typedef enum logic [1:0] {ROW_REG, ROW_BYTE, ROW_CHECKED} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [31:0] data;
    pixel_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  ch0;
  logic [7:0]  ch1;
  logic [7:0]  ch2;
  logic [7:0]  ch3;
  logic [7:0]  run_length;
  logic        last_run;

  // shadow registers and parse state
  logic [1:0]  shadow_type;
  logic [2:0]  shadow_bpp;
  logic        shadow_alpha;
  logic [31:0] shadow_count;
  logic        want_packet;
  logic        rep_packet;
  logic [6:0]  packet_left;
  logic [1:0]  byte_idx;
  logic [23:0] held;
  logic [31:0] px_left;

  pixel_t pixel_q [$];
  logic   typed_on;
  pixel_t typed_px;
  logic   idle_on;
  logic   hold_off;
  int     mismatch_count;
  int     live_bytes;

  row_t script [SCRIPT_LEN] = '{
    '{ROW_BYTE,    '0,                  32'hab, '0},
    '{ROW_REG,     REG_PIXEL_COUNT,     32'd1,  '0},
    '{ROW_BYTE,    '0,                  32'h81, '0},
    '{ROW_BYTE,    '0,                  32'h10, '0},
    '{ROW_BYTE,    '0,                  32'h20, '0},
    '{ROW_BYTE,    '0,                  32'h30, '0},
    '{ROW_CHECKED, '0,                  32'h40, '{8'h30, 8'h20, 8'h10, 8'h40, 8'd1, 1'b1}},
    '{ROW_REG,     REG_BYTES_PER_PIXEL, 32'd7,  '0},
    '{ROW_REG,     REG_ALPHA_ENABLE,    32'd0,  '0},
    '{ROW_REG,     REG_PIXEL_COUNT,     32'd1,  '0},
    '{ROW_BYTE,    '0,                  32'h7f, '0},
    '{ROW_BYTE,    '0,                  32'hff, '0},
    '{ROW_BYTE,    '0,                  32'h00, '0},
    '{ROW_BYTE,    '0,                  32'hff, '0},
    '{ROW_CHECKED, '0,                  32'h00, '{8'hff, 8'h00, 8'hff, 8'hff, 8'd1, 1'b1}},
    '{ROW_REG,     REG_BYTES_PER_PIXEL, 32'd0,  '0},
    '{ROW_REG,     REG_PIXEL_COUNT,     32'd200, '0},
    '{ROW_BYTE,    '0,                  32'hff, '0},
    '{ROW_BYTE,    '0,                  32'hff, '0},
    '{ROW_CHECKED, '0,                  32'hff, '{8'hff, 8'hff, 8'h00, 8'h00, 8'd128, 1'b0}},
    '{ROW_REG,     REG_IMAGE_TYPE,      {30'd0, IMG_RAW_COLOR}, '0},
    '{ROW_REG,     REG_BYTES_PER_PIXEL, 32'd2,  '0},
    '{ROW_REG,     REG_ALPHA_ENABLE,    32'd1,  '0},
    '{ROW_REG,     REG_PIXEL_COUNT,     32'd2,  '0},
    '{ROW_BYTE,    '0,                  32'h00, '0},
    '{ROW_CHECKED, '0,                  32'h80, '{8'h01, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0}},
    '{ROW_BYTE,    '0,                  32'hff, '0},
    '{ROW_CHECKED, '0,                  32'h7f, '{8'hfe, 8'hff, 8'h00, 8'h00, 8'd1, 1'b1}},
    '{ROW_REG,     REG_IMAGE_TYPE,      {30'd0, IMG_RLE_GRAY}, '0},
    '{ROW_REG,     REG_BYTES_PER_PIXEL, 32'd3,  '0},
    '{ROW_REG,     REG_PIXEL_COUNT,     32'd2,  '0},
    '{ROW_BYTE,    '0,                  32'h01, '0},
    '{ROW_BYTE,    '0,                  32'h11, '0},
    '{ROW_BYTE,    '0,                  32'h22, '0},
    '{ROW_CHECKED, '0,                  32'h33, '{8'h11, 8'h22, 8'h00, 8'h00, 8'd1, 1'b0}},
    '{ROW_BYTE,    '0,                  32'h44, '0},
    '{ROW_BYTE,    '0,                  32'h55, '0},
    // pixel size shrinks with two bytes held: completes on the next byte
    '{ROW_REG,     REG_BYTES_PER_PIXEL, 32'd2,  '0},
    '{ROW_BYTE,    '0,                  32'h66, '0}
  };

  tga_rle_pixel_decoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ch0        (ch0),
    .ch1        (ch1),
    .ch2        (ch2),
    .ch3        (ch3),
    .run_length (run_length),
    .last_run   (last_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pixel_bytes(input logic [2:0] bpp);
    if (bpp < 3'd2) return 2;
    if (bpp > 3'd4) return 4;
    return int'(bpp);
  endfunction

  function automatic void restart_image();
    want_packet = 1'b1;
    rep_packet  = 1'b0;
    packet_left = '0;
    byte_idx    = '0;
    held        = '0;
    px_left     = shadow_count;
  endfunction

  function automatic void write_shadow(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_IMAGE_TYPE:      shadow_type  = data[1:0];
      REG_BYTES_PER_PIXEL: shadow_bpp   = data[2:0];
      REG_ALPHA_ENABLE:    shadow_alpha = data[0];
      REG_PIXEL_COUNT: begin
        shadow_count = data;
        restart_image();
      end
      default: ;
    endcase
  endfunction

  function automatic logic decode_byte(input logic [7:0] b, output pixel_t px);
    logic [7:0]  lane [4];
    logic [15:0] word;
    logic [31:0] run;
    int          size;
    px = '0;
    if (px_left == 0) return 1'b0;
    if (shadow_type[0] && want_packet) begin
      rep_packet  = b[7];
      packet_left = b[6:0];
      want_packet = 1'b0;
      return 1'b0;
    end
    size = pixel_bytes(shadow_bpp);
    if (byte_idx < size - 1) begin
      held = held | (24'(b) << (8 * byte_idx));
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
    end
    lane[0] = held[7:0];
    lane[1] = held[15:8];
    lane[2] = held[23:16];
    lane[3] = 8'h00;
    lane[size - 1] = b;
    held = '0;
    byte_idx = '0;
    if (shadow_type[1]) begin
      px.ch0 = lane[0];
      px.ch1 = shadow_alpha ? lane[1] : 8'hff;
    end else if (size == 2) begin
      // ARGB1555 -> RGBA5551
      word = {lane[1], lane[0]};
      word = {word[14:0], shadow_alpha ? word[15] : 1'b1};
      px.ch0 = word[7:0];
      px.ch1 = word[15:8];
    end else begin
      px.ch0 = lane[2];
      px.ch1 = lane[1];
      px.ch2 = lane[0];
      if (size == 4) px.ch3 = shadow_alpha ? lane[3] : 8'hff;
    end
    run = 1;
    if (shadow_type[0]) begin
      if (rep_packet) begin
        run = packet_left + 1;
        packet_left = '0;
        want_packet = 1'b1;
      end else if (packet_left == 0) begin
        want_packet = 1'b1;
      end else begin
        packet_left = packet_left - 7'd1;
      end
    end
    if (run > px_left) run = px_left;
    px_left = px_left - run;
    px.run_len = run[7:0];
    px.last = (px_left == 0);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t guess;
    pixel_t want;
    logic   made;
    if (!rst) begin
      if (cfg_valid && cfg_ready) write_shadow(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        if (px_left != 0) live_bytes++;
        made = decode_byte(in_byte, guess);
        if (typed_on) begin
          made = 1'b1;
          guess = typed_px;
        end
        if (made) pixel_q.push_back(guess);
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel out with none expected: ch0 %0h ch1 %0h run %0d", ch0, ch1, run_length);
          mismatch_count++;
        end else begin
          want = pixel_q.pop_front();
          check_field("ch0", want.ch0, ch0);
          check_field("ch1", want.ch1, ch1);
          check_field("ch2", want.ch2, ch2);
          check_field("ch3", want.ch3, ch3);
          check_field("run_length", want.run_len, run_length);
          check_field("last_run", {7'd0, want.last}, {7'd0, last_run});
        end
      end
    end
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic chk, input pixel_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    typed_on <= chk;
    typed_px <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          phase;
    int          target;
    int          covered;
    int          npix;
    int          n;
    int          size;
    logic        rep;
    logic [1:0]  img;
    logic [2:0]  bpp;
    logic        alpha;
    logic [31:0] count;
    logic [31:0] data;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_IMAGE_TYPE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_byte        = '0;
    typed_on       = 1'b0;
    typed_px       = '0;
    idle_on        = 1'b1;
    hold_off       = 1'b0;
    mismatch_count = 0;
    live_bytes     = 0;
    shadow_type    = IMG_RLE_COLOR;
    shadow_bpp     = 3'd4;
    shadow_alpha   = 1'b1;
    shadow_count   = '0;
    restart_image();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (script[r].kind == ROW_REG) begin
        settle();
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_byte(script[r].data[7:0], script[r].kind == ROW_CHECKED, script[r].want);
      end
    end

    live_bytes = 0;
    phase = 0;
    while (live_bytes < BYTE_GOAL) begin
      idle_on = (live_bytes < CALM_FROM) && ($urandom_range(0, 4) != 0);
      img   = 2'($urandom_range(0, 3));
      bpp   = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
      alpha = 1'($urandom_range(0, 1));
      count = ($urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
      if (phase == 1) count = 32'hfffe_0001;
      if (phase == 2) begin
        // fill the pipeline behind a stalled receiver
        img = IMG_RAW_COLOR;
        bpp = 3'd2;
        count = 32'd40;
        idle_on = 1'b0;
      end
      settle();
      data = $urandom;
      data[1:0] = img;
      write_reg(REG_IMAGE_TYPE, data);
      data = $urandom;
      data[2:0] = bpp;
      write_reg(REG_BYTES_PER_PIXEL, data);
      data = $urandom;
      data[0] = alpha;
      write_reg(REG_ALPHA_ENABLE, data);
      write_reg(REG_PIXEL_COUNT, count);
      if (phase == 2) hold_off = 1'b1;
      size = pixel_bytes(bpp);
      target = (count > 40) ? 24 : int'(count);
      covered = 0;
      while (covered < target) begin
        if (img[0]) begin
          rep = 1'($urandom_range(0, 1));
          n = (rep && $urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
          send_byte({rep, 7'(n)}, 1'b0, '0);
          npix = rep ? 1 : n + 1;
          covered += n + 1;
        end else begin
          npix = 1;
          covered += 1;
        end
        repeat (npix * size) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      // trailing junk: dropped, or a partial pixel cut off by the next restart
      if (target == 0 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      phase++;
    end

    idle_on = 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("tga_rle_pixel_decoder_unit_tb: done, clean");
    end else begin
      $display("tga_rle_pixel_decoder_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tga_rle_pixel_decoder_unit_tb: done, errors");
    $finish;
  end

endmodule
